/* rtl/r2luv_pkg.sv */
//------------------------------------------------------------------------------
// r2luv_pkg
// Shared widths, matrix constants and white-point chromaticity for the
// RGB to CIE L*u*v* converter.
//------------------------------------------------------------------------------
`default_nettype none

package r2luv_pkg;

	// Default number of fraction bits on the L*, u*, v* outputs
	localparam int FRAC_BITS_DEF = 8;

	// Port field widths
	localparam int CH_W = 8;
	localparam int L_OUT_W = 15;
	localparam int UV_OUT_W = 17;

	// sRGB/D65 matrix, entries scaled by 1e6
	localparam int M_XR = 412453;
	localparam int M_XG = 357580;
	localparam int M_XB = 180423;
	localparam int M_YR = 212671;
	localparam int M_YG = 715160;
	localparam int M_YB = 72169;
	localparam int M_ZR = 19334;
	localparam int M_ZG = 119193;
	localparam int M_ZB = 950227;

	// Internal XYZ and denominator widths
	localparam int X_W = 28;
	localparam int Y_W = 28;
	localparam int Z_W = 29;
	localparam int D_W = 33;

	// Divider: numerator width and quotient bits (one bit per stage)
	localparam int DIV_A_W = 32;
	localparam int DIV_LAT = 33;

	// Cube root: result bits (one bit per stage)
	localparam int CB_W = 21;
	localparam int CB_LAT = CB_W;

	// White point sums and chromaticity (u'n, v' n scaled by 2^32, rounded)
	localparam longint XN_SUM = 950456;
	localparam longint YN_SUM = 1000000;
	localparam longint ZN_SUM = 1088754;
	localparam longint DN_SUM = XN_SUM + 15 * YN_SUM + 3 * ZN_SUM;
	localparam logic [DIV_LAT-1:0] UNP =
		DIV_LAT'((((64'd4 * XN_SUM) << 32) + DN_SUM / 2) / DN_SUM);
	localparam logic [DIV_LAT-1:0] VNP =
		DIV_LAT'((((64'd9 * YN_SUM) << 32) + DN_SUM / 2) / DN_SUM);

	// Lightness branch limit and constants
	localparam int LIN_LIMIT = 2267136;
	localparam int LIN_MUL = 9033;
	localparam longint LIN_HALF = 1280000000;
	localparam int LIN_DEN = 78125;
	localparam int CUBE_MUL = 116;
	localparam int CUBE_SUB = 26214400;
	localparam int CUBE_HALF = 819200;
	localparam int CUBE_DEN = 25;

	typedef logic [D_W-1:0] dsum_t;
	typedef logic [DIV_LAT-1:0] chroma_t;
	typedef logic [CB_W-1:0] croot_t;

endpackage

`default_nettype wire

/* rtl/r2luv_div.sv */
//------------------------------------------------------------------------------
// r2luv_div
// Pipelined restoring divider: quo = round_half_up(num * 2^32 / den),
// one quotient bit per stage.
//------------------------------------------------------------------------------
`default_nettype none

module r2luv_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [r2luv_pkg::DIV_A_W-1:0] num,
	input  wire r2luv_pkg::dsum_t              den,
	output r2luv_pkg::chroma_t                 quo
);

	localparam int STEPS = r2luv_pkg::DIV_LAT;
	localparam int DW = r2luv_pkg::D_W;
	localparam int NW = r2luv_pkg::DIV_A_W + 32 + 1;

	logic [DW-1:0]    rem_s [STEPS-1];
	logic [STEPS-1:0] nb_s  [STEPS-1];
	logic [DW-1:0]    den_s [STEPS-1];
	logic [STEPS-1:0] q_s   [STEPS];
	logic [NW-1:0]    nfull;

	// Numerator with half the divisor added for rounding
	assign nfull = {1'b0, num, 32'b0} + NW'(den >> 1);

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [DW-1:0]    rin;
		logic [STEPS-1:0] nin;
		logic [STEPS-1:0] qin;
		logic [DW-1:0]    din;
		logic [DW:0]      trial;
		logic             ge;
		logic [DW-1:0]    rnext;

		if (k == 0) begin : g_first
			assign rin = DW'(nfull[NW-1:STEPS]);
			assign nin = nfull[STEPS-1:0];
			assign qin = '0;
			assign din = den;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign nin = nb_s[k-1];
			assign qin = q_s[k-1];
			assign din = den_s[k-1];
		end

		// Shift in the next numerator bit and try a subtract
		assign trial = {rin, nin[STEPS-1]};
		assign ge = trial >= {1'b0, din};
		assign rnext = ge ? DW'(trial - {1'b0, din}) : DW'(trial);

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k] <= {qin[STEPS-2:0], ge};
			end
		end

		if (k < STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= rnext;
					nb_s[k] <= nin << 1;
					den_s[k] <= din;
				end
			end
		end
	end

	assign quo = q_s[STEPS-1];

endmodule

`default_nettype wire

/* rtl/r2luv_cbrt.sv */
//------------------------------------------------------------------------------
// r2luv_cbrt
// Pipelined integer cube root of y * 2^34, one result bit per stage.
// Square and cube of the partial root are kept so each stage is shifts and adds.
//------------------------------------------------------------------------------
`default_nettype none

module r2luv_cbrt (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [r2luv_pkg::Y_W-1:0] y,
	output r2luv_pkg::croot_t              root
);

	localparam int STEPS = r2luv_pkg::CB_LAT;
	localparam int CW = r2luv_pkg::CB_W;
	localparam int YW = r2luv_pkg::Y_W;

	logic [CW-1:0]   c_s  [STEPS];
	logic [2*CW-1:0] c2_s [STEPS-1];
	logic [63:0]     c3_s [STEPS-1];
	logic [YW-1:0]   y_s  [STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int B = CW - 1 - k;
		logic [CW-1:0]   cin;
		logic [2*CW-1:0] c2in;
		logic [63:0]     c3in;
		logic [YW-1:0]   yin;
		logic [63:0]     n;
		logic [63:0]     t3;
		logic [2*CW-1:0] t2;
		logic            fits;

		if (k == 0) begin : g_first
			assign cin = '0;
			assign c2in = '0;
			assign c3in = '0;
			assign yin = y;
		end else begin : g_next
			assign cin = c_s[k-1];
			assign c2in = c2_s[k-1];
			assign c3in = c3_s[k-1];
			assign yin = y_s[k-1];
		end

		// (c + 2^B)^3 and (c + 2^B)^2 from the running terms
		assign n = 64'({yin, 34'b0});
		assign t3 = c3in + ((64'(c2in) * 64'd3) << B)
			+ ((64'(cin) * 64'd3) << (2 * B)) + (64'd1 << (3 * B));
		assign t2 = c2in + ((2 * CW)'(cin) << (B + 1)) + ((2 * CW)'(1) << (2 * B));
		assign fits = t3 <= n;

		always_ff @(posedge clk) begin
			if (en) begin
				c_s[k] <= fits ? (cin | (CW'(1) << B)) : cin;
			end
		end

		if (k < STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					c2_s[k] <= fits ? t2 : c2in;
					c3_s[k] <= fits ? t3 : c3in;
					y_s[k] <= yin;
				end
			end
		end
	end

	assign root = c_s[STEPS-1];

endmodule

`default_nettype wire

/* rtl/rgb_to_cie_luv.sv */
//------------------------------------------------------------------------------
// rgb_to_cie_luv
// Streaming sRGB/D65 to CIE L*u*v* converter with fixed-point outputs.
//------------------------------------------------------------------------------
// Takes one pixel per clock when the output is not stalled and returns its
// L*u*v* result in order. The deepest branch is the u'/v' dividers, which
// resolve one quotient bit per stage over 33 stages; the cube root for L*
// runs beside them (21 stages) and its result waits in a short delay line.
// A stall on the output freezes the whole pipeline, so the input stall follows
// the output stall while a result is waiting. No startup pass after reset.
//------------------------------------------------------------------------------
`default_nettype none

module rgb_to_cie_luv #(
	parameter int FRAC_BITS = r2luv_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 pix_valid,
	output logic                                      pix_stall,
	input  wire logic [r2luv_pkg::CH_W-1:0]           red,
	input  wire logic [r2luv_pkg::CH_W-1:0]           green,
	input  wire logic [r2luv_pkg::CH_W-1:0]           blue,
	input  wire logic                                 last_pixel,
	output logic                                      luv_valid,
	input  wire logic                                 luv_stall,
	output logic [r2luv_pkg::L_OUT_W-1:0]             lightness,
	output logic signed [r2luv_pkg::UV_OUT_W-1:0]     u_star,
	output logic signed [r2luv_pkg::UV_OUT_W-1:0]     v_star,
	output logic                                      last_out
);

	localparam int F = FRAC_BITS;

	// Stage map
	localparam int S_D = 2;
	localparam int S_CB = S_D + r2luv_pkg::CB_LAT;
	localparam int S_L = S_CB + 3;
	localparam int S_DV = S_D + r2luv_pkg::DIV_LAT;
	localparam int LQ_DLY = S_DV - S_L;
	localparam int S_OUT = S_DV + 4;

	// Lightness widths
	localparam int LQ_W = 7 + F;
	localparam int Q_W = 13 + F;
	localparam logic [LQ_W-1:0] LMAX = LQ_W'(100) << F;

	// Linear branch: m = N >> 15, then divide by 78125
	localparam int NL_W = 36 + F;
	localparam int ML_W = 21 + F;
	localparam int MLR_W = ML_W - 16;
	localparam logic [MLR_W-1:0] ML_RECIP = MLR_W'((64'd1 << ML_W) / 64'd78125);

	// Cube branch: m = N >> 16, then divide by 25
	localparam int NC_W = 29 + F;
	localparam int MC_W = 13 + F;
	localparam int MCR_W = MC_W - 4;
	localparam logic [MCR_W-1:0] MC_RECIP = MCR_W'((64'd1 << MC_W) / 64'd25);

	// Chroma scaling widths
	localparam int L13_W = 11 + F;
	localparam int P_W = 45 + F;
	localparam int RR_W = P_W - 32;
	localparam int UM_W = 8 + F;
	localparam int VW = 9 + F;
	localparam logic [UM_W-1:0] ULIM = UM_W'(200) << F;
	localparam int SX_W = (VW > r2luv_pkg::UV_OUT_W) ? VW : r2luv_pkg::UV_OUT_W;
	localparam int LX_W = (LQ_W > r2luv_pkg::L_OUT_W) ? LQ_W : r2luv_pkg::L_OUT_W;

	logic en;

	logic                          vld_s  [1:S_OUT];
	logic                          last_s [1:S_OUT];

	logic [r2luv_pkg::X_W-1:0]     x_s1;
	logic [r2luv_pkg::Y_W-1:0]     y_s1;
	logic [r2luv_pkg::Z_W-1:0]     z_s1;
	logic [r2luv_pkg::Y_W-1:0]     y_s2;
	r2luv_pkg::dsum_t              d_s2;
	logic [r2luv_pkg::DIV_A_W-1:0] au_s2;
	logic [r2luv_pkg::DIV_A_W-1:0] av_s2;

	logic [r2luv_pkg::Y_W-1:0]     ydly_s [r2luv_pkg::CB_LAT];
	r2luv_pkg::croot_t             root;
	r2luv_pkg::chroma_t            up;
	r2luv_pkg::chroma_t            vp;

	logic [ML_W-1:0]               ml_s24;
	logic [MC_W-1:0]               mc_s24;
	logic                          lin_s24;
	logic                          pos_s24;
	logic [ML_W-1:0]               ml_s25;
	logic [MC_W-1:0]               mc_s25;
	logic [MLR_W-1:0]              ql_s25;
	logic [MCR_W-1:0]              qc_s25;
	logic                          lin_s25;
	logic                          pos_s25;
	logic [LQ_W-1:0]               lq_s26;
	logic [LQ_W-1:0]               lqd_s [LQ_DLY];

	logic [L13_W-1:0]              l13_s36;
	logic [r2luv_pkg::DIV_LAT-1:0] mu_s36;
	logic [r2luv_pkg::DIV_LAT-1:0] mv_s36;
	logic                          nu_s36;
	logic                          nv_s36;
	logic [LQ_W-1:0]               lq_s36;
	logic [L13_W+16:0]             plu_s37;
	logic [L13_W+15:0]             phu_s37;
	logic [L13_W+16:0]             plv_s37;
	logic [L13_W+15:0]             phv_s37;
	logic                          nu_s37;
	logic                          nv_s37;
	logic [LQ_W-1:0]               lq_s37;
	logic [RR_W-1:0]               ru_s38;
	logic [RR_W-1:0]               rv_s38;
	logic                          nu_s38;
	logic                          nv_s38;
	logic [LQ_W-1:0]               lq_s38;
	logic [LQ_W-1:0]               lq_s39;
	logic [VW-1:0]                 usv_s39;
	logic [VW-1:0]                 vsv_s39;

	// Advance unless a finished result is held by the output stall
	assign en = !(vld_s[S_OUT] && luv_stall);
	assign pix_stall = !en;

	// Valid bits, reset with the control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= S_OUT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= pix_valid;
			for (int i = 2; i <= S_OUT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Carry the last-pixel flag alongside
	always_ff @(posedge clk) begin
		if (en) begin
			last_s[1] <= last_pixel;
			for (int i = 2; i <= S_OUT; i++) begin
				last_s[i] <= last_s[i-1];
			end
		end
	end

	// Stage 1: XYZ by the fixed matrix
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= r2luv_pkg::X_W'(32'(red) * 32'(r2luv_pkg::M_XR)
				+ 32'(green) * 32'(r2luv_pkg::M_XG) + 32'(blue) * 32'(r2luv_pkg::M_XB));
			y_s1 <= r2luv_pkg::Y_W'(32'(red) * 32'(r2luv_pkg::M_YR)
				+ 32'(green) * 32'(r2luv_pkg::M_YG) + 32'(blue) * 32'(r2luv_pkg::M_YB));
			z_s1 <= r2luv_pkg::Z_W'(32'(red) * 32'(r2luv_pkg::M_ZR)
				+ 32'(green) * 32'(r2luv_pkg::M_ZG) + 32'(blue) * 32'(r2luv_pkg::M_ZB));
		end
	end

	// Stage 2: chroma denominator and divider numerators
	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= y_s1;
			d_s2 <= r2luv_pkg::D_W'(35'(x_s1) + 35'(y_s1) * 35'(15) + 35'(z_s1) * 35'(3));
			au_s2 <= r2luv_pkg::DIV_A_W'({x_s1, 2'b00});
			av_s2 <= r2luv_pkg::DIV_A_W'(36'(y_s1) * 36'(9));
		end
	end

	// u' and v' dividers
	r2luv_div u_div_i (
		.clk (clk),
		.en  (en),
		.num (au_s2),
		.den (d_s2),
		.quo (up)
	);

	r2luv_div v_div_i (
		.clk (clk),
		.en  (en),
		.num (av_s2),
		.den (d_s2),
		.quo (vp)
	);

	// Cube root of Y for the upper lightness branch
	r2luv_cbrt cbrt_i (
		.clk  (clk),
		.en   (en),
		.y    (y_s2),
		.root (root)
	);

	// Hold Y beside the cube root
	always_ff @(posedge clk) begin
		if (en) begin
			ydly_s[0] <= y_s2;
			for (int i = 1; i < r2luv_pkg::CB_LAT; i++) begin
				ydly_s[i] <= ydly_s[i-1];
			end
		end
	end

	// L1: rounded numerators of both lightness branches, pre-shifted
	always_ff @(posedge clk) begin : p_l1
		logic [r2luv_pkg::Y_W-1:0] yv;
		logic [NL_W-1:0]           nlin;
		logic [27:0]               c116;
		logic [NC_W-1:0]           ncub;
		yv = ydly_s[r2luv_pkg::CB_LAT-1];
		nlin = (NL_W'(yv) * NL_W'(r2luv_pkg::LIN_MUL) << F) + NL_W'(r2luv_pkg::LIN_HALF);
		c116 = 28'(28'(root) * 28'(r2luv_pkg::CUBE_MUL));
		ncub = (NC_W'(c116 - 28'(r2luv_pkg::CUBE_SUB)) << F)
			+ NC_W'(r2luv_pkg::CUBE_HALF);
		if (en) begin
			ml_s24 <= nlin[NL_W-1:15];
			mc_s24 <= ncub[NC_W-1:16];
			lin_s24 <= yv < r2luv_pkg::Y_W'(r2luv_pkg::LIN_LIMIT);
			pos_s24 <= c116 > 28'(r2luv_pkg::CUBE_SUB);
		end
	end

	// L2: quotient estimates by reciprocal multiply
	always_ff @(posedge clk) begin : p_l2
		logic [ML_W+MLR_W-1:0] pl;
		logic [MC_W+MCR_W-1:0] pc;
		pl = (ML_W + MLR_W)'(ml_s24) * (ML_W + MLR_W)'(ML_RECIP);
		pc = (MC_W + MCR_W)'(mc_s24) * (MC_W + MCR_W)'(MC_RECIP);
		if (en) begin
			ml_s25 <= ml_s24;
			mc_s25 <= mc_s24;
			ql_s25 <= pl[ML_W+MLR_W-1:ML_W];
			qc_s25 <= pc[MC_W+MCR_W-1:MC_W];
			lin_s25 <= lin_s24;
			pos_s25 <= pos_s24;
		end
	end

	// L3: correct the estimates by one, pick the branch, saturate
	always_ff @(posedge clk) begin : p_l3
		logic [ML_W-1:0] rl;
		logic [MC_W-1:0] rc;
		logic [Q_W-1:0]  ql;
		logic [Q_W-1:0]  qc;
		logic [Q_W-1:0]  qsel;
		rl = ml_s25 - ML_W'(ML_W'(ql_s25) * ML_W'(r2luv_pkg::LIN_DEN));
		rc = mc_s25 - MC_W'(MC_W'(qc_s25) * MC_W'(r2luv_pkg::CUBE_DEN));
		ql = Q_W'(ql_s25) + Q_W'(rl >= ML_W'(r2luv_pkg::LIN_DEN));
		qc = Q_W'(qc_s25) + Q_W'(rc >= MC_W'(r2luv_pkg::CUBE_DEN));
		if (lin_s25) begin
			qsel = ql;
		end else if (pos_s25) begin
			qsel = qc;
		end else begin
			qsel = '0;
		end
		if (en) begin
			lq_s26 <= (qsel > Q_W'(LMAX)) ? LMAX : LQ_W'(qsel);
		end
	end

	// Hold L* until the chroma quotients arrive
	always_ff @(posedge clk) begin
		if (en) begin
			lqd_s[0] <= lq_s26;
			for (int i = 1; i < LQ_DLY; i++) begin
				lqd_s[i] <= lqd_s[i-1];
			end
		end
	end

	// M1: chroma differences to sign and magnitude, 13 * L*
	always_ff @(posedge clk) begin : p_m1
		logic [r2luv_pkg::DIV_LAT:0] du;
		logic [r2luv_pkg::DIV_LAT:0] dv;
		logic [r2luv_pkg::DIV_LAT:0] du_n;
		logic [r2luv_pkg::DIV_LAT:0] dv_n;
		du = {1'b0, up} - {1'b0, r2luv_pkg::UNP};
		dv = {1'b0, vp} - {1'b0, r2luv_pkg::VNP};
		du_n = -du;
		dv_n = -dv;
		if (en) begin
			l13_s36 <= L13_W'(lqd_s[LQ_DLY-1]) * L13_W'(13);
			lq_s36 <= lqd_s[LQ_DLY-1];
			nu_s36 <= du[r2luv_pkg::DIV_LAT];
			nv_s36 <= dv[r2luv_pkg::DIV_LAT];
			mu_s36 <= du[r2luv_pkg::DIV_LAT] ? du_n[r2luv_pkg::DIV_LAT-1:0]
				: du[r2luv_pkg::DIV_LAT-1:0];
			mv_s36 <= dv[r2luv_pkg::DIV_LAT] ? dv_n[r2luv_pkg::DIV_LAT-1:0]
				: dv[r2luv_pkg::DIV_LAT-1:0];
		end
	end

	// M2: partial products on the split magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			plu_s37 <= (L13_W + 17)'(l13_s36) * (L13_W + 17)'(mu_s36[16:0]);
			phu_s37 <= (L13_W + 16)'(l13_s36) * (L13_W + 16)'(mu_s36[32:17]);
			plv_s37 <= (L13_W + 17)'(l13_s36) * (L13_W + 17)'(mv_s36[16:0]);
			phv_s37 <= (L13_W + 16)'(l13_s36) * (L13_W + 16)'(mv_s36[32:17]);
			nu_s37 <= nu_s36;
			nv_s37 <= nv_s36;
			lq_s37 <= lq_s36;
		end
	end

	// M3: sum the partials and round the magnitude at bit 32
	always_ff @(posedge clk) begin : p_m3
		logic [P_W-1:0] su;
		logic [P_W-1:0] sv;
		su = P_W'(plu_s37) + (P_W'(phu_s37) << 17) + (P_W'(1) << 31);
		sv = P_W'(plv_s37) + (P_W'(phv_s37) << 17) + (P_W'(1) << 31);
		if (en) begin
			ru_s38 <= su[P_W-1:32];
			rv_s38 <= sv[P_W-1:32];
			nu_s38 <= nu_s37;
			nv_s38 <= nv_s37;
			lq_s38 <= lq_s37;
		end
	end

	// Output stage: saturate, restore sign, zero chroma for black
	always_ff @(posedge clk) begin : p_out
		logic [VW-1:0] um;
		logic [VW-1:0] vm;
		um = VW'((ru_s38 > RR_W'(ULIM)) ? ULIM : UM_W'(ru_s38));
		vm = VW'((rv_s38 > RR_W'(ULIM)) ? ULIM : UM_W'(rv_s38));
		if (en) begin
			lq_s39 <= lq_s38;
			if (lq_s38 == '0) begin
				usv_s39 <= '0;
				vsv_s39 <= '0;
			end else begin
				usv_s39 <= nu_s38 ? (~um + 1'b1) : um;
				vsv_s39 <= nv_s38 ? (~vm + 1'b1) : vm;
			end
		end
	end

	// Drive the ports at the fixed field widths
	always_comb begin
		logic [LX_W-1:0] lw;
		logic [SX_W-1:0] uw;
		logic [SX_W-1:0] vw;
		lw = LX_W'(lq_s39);
		uw = SX_W'($signed(usv_s39));
		vw = SX_W'($signed(vsv_s39));
		lightness = lw[r2luv_pkg::L_OUT_W-1:0];
		u_star = $signed(uw[r2luv_pkg::UV_OUT_W-1:0]);
		v_star = $signed(vw[r2luv_pkg::UV_OUT_W-1:0]);
	end

	assign luv_valid = vld_s[S_OUT];
	assign last_out = last_s[S_OUT];

	// L* never exceeds 100
	a_l_range: assert property (@(posedge clk) disable iff (!arst_n)
		luv_valid |-> (lq_s39 <= LMAX))
		else $error("lightness above full scale");

	// Black gives zero chroma
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(luv_valid && lq_s39 == '0) |-> (usv_s39 == '0 && vsv_s39 == '0))
		else $error("nonzero chroma for zero lightness");

	// Chroma stays within +-200
	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		luv_valid |-> ($signed(usv_s39) <= $signed({1'b0, ULIM})
			&& $signed(usv_s39) >= -$signed({1'b0, ULIM})
			&& $signed(vsv_s39) <= $signed({1'b0, ULIM})
			&& $signed(vsv_s39) >= -$signed({1'b0, ULIM})))
		else $error("chroma outside saturation range");

	// Input is held off only while a result waits on the output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (luv_valid && luv_stall))
		else $error("input stalled without a held result");

endmodule

`default_nettype wire
